[hw/rtl/iee_pkg.sv]
package iee_pkg;

    localparam logic [2:0] OP_LPAREN = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIVZERO   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;

    // request to the arithmetic unit
    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } alu_req_t;

    function automatic logic [1:0] prec(input logic [2:0] op);
        logic [1:0] p;
        begin
            p = 2'd0;
            if (op == OP_MUL || op == OP_DIV)
                p = 2'd2;
            else if (op == OP_ADD || op == OP_SUB)
                p = 2'd1;
            return p;
        end
    endfunction

endpackage

[hw/rtl/iee_alu.sv]
module iee_alu #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iee_pkg::alu_req_t      req,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] shifted;

    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        shifted   = {rem_reg[VALUE_WIDTH-2:0], quo_reg[VALUE_WIDTH-1]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        if (req.start) begin
            case (req.op)
                iee_pkg::OP_ADD:
                begin
                    res_next  = a + b;
                    done_next = 1'b1;
                end
                iee_pkg::OP_SUB:
                begin
                    res_next  = a - b;
                    done_next = 1'b1;
                end
                iee_pkg::OP_MUL:
                begin
                    res_next  = a * b;
                    done_next = 1'b1;
                end
                default:
                begin
                    busy_next = 1'b1;
                    cnt_next  = CW'(VALUE_WIDTH);
                    quo_next  = a[VALUE_WIDTH-1] ? -a : a;
                    dvs_next  = b[VALUE_WIDTH-1] ? -b : b;
                    rem_next  = '0;
                    neg_next  = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
                end
            endcase
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -quo_reg : quo_reg;
            end else begin
                // one restoring step per cycle
                cnt_next = cnt_reg - 1'b1;
                if (!trial[VALUE_WIDTH]) begin
                    rem_next = trial[VALUE_WIDTH-1:0];
                    quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

endmodule

[hw/rtl/infix_expression_evaluator_unit.sv]
// Divisions use a restoring divider (one bit a cycle).
// One character in flight at a time.
// Reset (rst_n, async low) empties both stacks and clears the error.
module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] value,
    output logic [1:0]  status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_LOOP   = 4'd2;
    localparam logic [3:0] S_RD1    = 4'd3;
    localparam logic [3:0] S_RD2    = 4'd4;
    localparam logic [3:0] S_WAIT   = 4'd5;
    localparam logic [3:0] S_PUSHOP = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_RDRES  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_ALU    = 4'd11;

    // loop modes
    localparam logic [1:0] M_OPER  = 2'd0;
    localparam logic [1:0] M_CLOSE = 2'd1;
    localparam logic [1:0] M_END   = 2'd2;

    logic [VALUE_WIDTH-1:0] opd_mem [STACK_DEPTH];
    logic [2:0]             opr_mem [STACK_DEPTH];

    logic [3:0]  state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic [TW-1:0] dtop_reg, dtop_next;
    logic [TW-1:0] otop_reg, otop_next;
    logic [1:0]  err_reg, err_next;
    logic [7:0]  ch_reg;
    logic        last_reg;
    logic [2:0]  newop_reg, newop_next;
    logic [2:0]  topop_reg;
    logic [2:0]  redop_reg, redop_next;
    logic [VALUE_WIDTH-1:0] rd_reg, opa_reg, opb_reg;
    logic        opa_load, opb_load;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] ord_addr;
    logic        dwr;
    logic [AW-1:0] dwr_addr;
    logic [VALUE_WIDTH-1:0] dwr_data;
    logic        owr;
    logic [2:0]  owr_data;
    logic        ov_reg, ov_next;
    logic [31:0] val_reg, val_next;
    logic [1:0]  st_reg, st_next;
    iee_pkg::alu_req_t req;
    logic        alu_done;
    logic [VALUE_WIDTH-1:0] alu_res;

    iee_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .a      (opa_reg),
        .b      (opb_reg),
        .done   (alu_done),
        .result (alu_res)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign value     = val_reg;
    assign status    = st_reg;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        dtop_next  = dtop_reg;
        otop_next  = otop_reg;
        err_next   = err_reg;
        newop_next = newop_reg;
        redop_next = redop_reg;
        rd_addr    = '0;
        ord_addr   = '0;
        opa_load   = 1'b0;
        opb_load   = 1'b0;
        dwr        = 1'b0;
        dwr_addr   = dtop_reg[AW-1:0];
        dwr_data   = '0;
        owr        = 1'b0;
        owr_data   = newop_reg;
        ov_next    = ov_reg && out_stall;
        val_next   = val_reg;
        st_next    = st_reg;
        req.start  = 1'b0;
        req.op     = redop_reg;
        if (otop_reg != '0)
            ord_addr = AW'(otop_reg - 1'b1);
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                state_next = last_reg ? S_FIN : S_DONE;
                if (err_reg == iee_pkg::ST_OK)
                begin
                    if (ch_reg inside {[iee_pkg::CH_ZERO:iee_pkg::CH_NINE]})
                    begin
                        if (dtop_reg == TW'(STACK_DEPTH))
                            err_next = iee_pkg::ST_OVERFLOW;
                        else
                        begin
                            dwr       = 1'b1;
                            dwr_data  = VALUE_WIDTH'(ch_reg - iee_pkg::CH_ZERO);
                            dtop_next = dtop_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        case (ch_reg)
                            iee_pkg::CH_LPAREN:
                            begin
                                newop_next = iee_pkg::OP_LPAREN;
                                state_next = S_PUSHOP;
                            end
                            iee_pkg::CH_RPAREN:
                            begin
                                mode_next  = M_CLOSE;
                                state_next = S_LOOP;
                            end
                            iee_pkg::CH_ADD:
                            begin
                                newop_next = iee_pkg::OP_ADD;
                                mode_next  = M_OPER;
                                state_next = S_LOOP;
                            end
                            iee_pkg::CH_SUB:
                            begin
                                newop_next = iee_pkg::OP_SUB;
                                mode_next  = M_OPER;
                                state_next = S_LOOP;
                            end
                            iee_pkg::CH_MUL:
                            begin
                                newop_next = iee_pkg::OP_MUL;
                                mode_next  = M_OPER;
                                state_next = S_LOOP;
                            end
                            iee_pkg::CH_DIV:
                            begin
                                newop_next = iee_pkg::OP_DIV;
                                mode_next  = M_OPER;
                                state_next = S_LOOP;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_LOOP:
            begin
                // topop_reg holds the operator at the top (read last cycle)
                if (err_reg != iee_pkg::ST_OK)
                begin
                    if (mode_reg == M_END)
                        state_next = S_RDRES;
                    else
                        state_next = last_reg ? S_FIN : S_DONE;
                end
                else if (mode_reg == M_OPER)
                begin
                    if (otop_reg == '0 || topop_reg == iee_pkg::OP_LPAREN ||
                        iee_pkg::prec(topop_reg) < iee_pkg::prec(newop_reg))
                        state_next = S_PUSHOP;
                    else
                        state_next = S_RD1;
                end
                else if (mode_reg == M_CLOSE)
                begin
                    if (otop_reg == '0)
                    begin
                        err_next   = iee_pkg::ST_MALFORMED;
                        state_next = last_reg ? S_FIN : S_DONE;
                    end
                    else if (topop_reg == iee_pkg::OP_LPAREN)
                    begin
                        otop_next  = otop_reg - 1'b1;
                        state_next = last_reg ? S_FIN : S_DONE;
                    end
                    else
                        state_next = S_RD1;
                end
                else
                begin
                    if (otop_reg == '0)
                        state_next = S_RDRES;
                    else if (topop_reg == iee_pkg::OP_LPAREN)
                    begin
                        err_next   = iee_pkg::ST_MALFORMED;
                        state_next = S_RDRES;
                    end
                    else
                        state_next = S_RD1;
                end
                if (state_next == S_RD1)
                begin
                    redop_next = topop_reg;
                    otop_next  = otop_reg - 1'b1;
                    if (dtop_reg < TW'(2))
                    begin
                        err_next   = iee_pkg::ST_MALFORMED;
                        state_next = S_LOOP;
                    end
                    else
                        rd_addr = AW'(dtop_reg - 1'b1);
                end
            end
            S_RD1:
            begin
                opb_load = 1'b1;
                rd_addr  = AW'(dtop_reg - TW'(2));
                state_next = S_RD2;
            end
            S_RD2:
            begin
                opa_load  = 1'b1;
                dtop_next = dtop_reg - TW'(2);
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (redop_reg == iee_pkg::OP_DIV && opb_reg == '0)
                begin
                    err_next   = iee_pkg::ST_DIVZERO;
                    state_next = S_LOOP;
                end
                else
                begin
                    req.start  = 1'b1;
                    state_next = S_ALU;
                end
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    // result always fits: two operands were popped
                    dwr       = 1'b1;
                    dwr_data  = alu_res;
                    dtop_next = dtop_reg + 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_PUSHOP:
            begin
                if (otop_reg == TW'(STACK_DEPTH))
                    err_next = iee_pkg::ST_OVERFLOW;
                else
                begin
                    owr       = 1'b1;
                    otop_next = otop_reg + 1'b1;
                end
                state_next = last_reg ? S_FIN : S_DONE;
            end
            S_FIN:
            begin
                mode_next  = M_END;
                state_next = S_LOOP;
            end
            S_RDRES:
            begin
                rd_addr = '0;
                if (err_reg == iee_pkg::ST_OK && dtop_reg != TW'(1))
                    err_next = iee_pkg::ST_MALFORMED;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next  = 1'b1;
                    st_next  = err_reg;
                    val_next = (err_reg == iee_pkg::ST_OK) ?
                               32'(signed'(rd_reg)) : 32'd0;
                    dtop_next = '0;
                    otop_next = '0;
                    err_next  = iee_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        // hold the first error until the result leaves
        if (err_reg != iee_pkg::ST_OK && state_reg != S_OUT)
            err_next = err_reg;
    end

    always_ff @(posedge clk)
    begin
        if (dwr)
            opd_mem[dwr_addr] <= dwr_data;
        rd_reg <= opd_mem[rd_addr];
        if (owr)
            opr_mem[otop_reg[AW-1:0]] <= owr_data;
        topop_reg <= opr_mem[owr ? otop_reg[AW-1:0] : ord_addr];
        if (opb_load)
            opb_reg <= rd_reg;
        if (opa_load)
            opa_reg <= rd_reg;
        if (in_valid && !in_stall)
        begin
            ch_reg   <= char_code;
            last_reg <= last_char;
        end
        newop_reg <= newop_next;
        redop_reg <= redop_next;
        val_reg   <= val_next;
        st_reg    <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= M_OPER;
            dtop_reg  <= '0;
            otop_reg  <= '0;
            err_reg   <= iee_pkg::ST_OK;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            dtop_reg  <= dtop_next;
            otop_reg  <= otop_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

[hw/rtl/iee_checker.sv]
module iee_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] value,
    input logic [1:0]  status
);

    // an accepted character blocks the next transfer: in_stall is high in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_value_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != iee_pkg::ST_OK |-> value == 32'd0)
        else $error("value not zero with error status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("stalled result changed");

endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
);

[bench/infix_expression_evaluator_unit_tb.sv]
`timescale 1ns / 1ps
module infix_expression_evaluator_unit_tb;

    localparam int DEPTH = 16;
    localparam int LIMIT_CYCLES = 4000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_code;
    logic        last_char;
    logic        out_valid;
    logic        out_stall;
    logic signed [31:0] value;
    logic [1:0]  status;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } outcome_t;

    outcome_t    expected_outcomes[$];
    logic [31:0] num_stack[DEPTH];
    int          num_count;
    logic [2:0]  op_stack[DEPTH];
    int          op_count;
    logic [1:0]  err;
    int          mismatches;
    int          cycles;
    bit          hold_off;
    bit          no_gaps;

    infix_expression_evaluator_unit #(.STACK_DEPTH(DEPTH), .VALUE_WIDTH(32)) uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .char_code(char_code), .last_char(last_char), .out_valid(out_valid),
        .out_stall(out_stall), .value(value), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------- evaluator model ----------------
    function automatic int rank(input logic [2:0] op);
        if (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV)
            return 2;
        if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB)
            return 1;
        return 0;
    endfunction

    task automatic raise(input logic [1:0] e);
        if (err == iee_pkg::ST_OK)
            err = e;
    endtask

    task automatic clear_eval();
        num_count = 0;
        op_count = 0;
        err = iee_pkg::ST_OK;
    endtask

    task automatic push_num(input logic [31:0] v);
        if (num_count >= DEPTH)
            raise(iee_pkg::ST_OVERFLOW);
        else
        begin
            num_stack[num_count] = v;
            num_count++;
        end
    endtask

    task automatic push_op(input logic [2:0] op);
        if (op_count >= DEPTH)
            raise(iee_pkg::ST_OVERFLOW);
        else
        begin
            op_stack[op_count] = op;
            op_count++;
        end
    endtask

    task automatic apply_top();
        logic [2:0] op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0] r;
        if (op_count == 0)
            return;
        op = op_stack[op_count - 1];
        op_count--;
        if (num_count < 2)
        begin
            raise(iee_pkg::ST_MALFORMED);
            return;
        end
        b = num_stack[num_count - 1];
        a = num_stack[num_count - 2];
        num_count -= 2;
        case (op)
            iee_pkg::OP_ADD: r = a + b;
            iee_pkg::OP_SUB: r = a - b;
            iee_pkg::OP_MUL: r = a * b;
            iee_pkg::OP_DIV:
            begin
                if (b == 0)
                begin
                    raise(iee_pkg::ST_DIVZERO);
                    return;
                end
                // most negative over -1 wraps back to itself
                if (a == 32'sh80000000 && b == -1)
                    r = a;
                else
                    r = a / b;
            end
            default:
            begin
                raise(iee_pkg::ST_MALFORMED);
                return;
            end
        endcase
        push_num(r);
    endtask

    task automatic take_op(input logic [2:0] op);
        while (err == iee_pkg::ST_OK && op_count > 0)
        begin
            if (op_stack[op_count - 1] == iee_pkg::OP_LPAREN
                || rank(op_stack[op_count - 1]) < rank(op))
                break;
            apply_top();
        end
        if (err == iee_pkg::ST_OK)
            push_op(op);
    endtask

    task automatic evaluate_char(input logic [7:0] c, input logic fin);
        outcome_t o;
        if (err == iee_pkg::ST_OK)
        begin
            if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE)
                push_num(32'(c - iee_pkg::CH_ZERO));
            else
                case (c)
                    iee_pkg::CH_LPAREN: push_op(iee_pkg::OP_LPAREN);
                    iee_pkg::CH_RPAREN:
                        while (err == iee_pkg::ST_OK)
                        begin
                            if (op_count == 0)
                            begin
                                raise(iee_pkg::ST_MALFORMED);
                                break;
                            end
                            if (op_stack[op_count - 1] == iee_pkg::OP_LPAREN)
                            begin
                                op_count--;
                                break;
                            end
                            apply_top();
                        end
                    iee_pkg::CH_ADD: take_op(iee_pkg::OP_ADD);
                    iee_pkg::CH_SUB: take_op(iee_pkg::OP_SUB);
                    iee_pkg::CH_MUL: take_op(iee_pkg::OP_MUL);
                    iee_pkg::CH_DIV: take_op(iee_pkg::OP_DIV);
                    default: ;
                endcase
        end
        if (!fin)
            return;
        while (err == iee_pkg::ST_OK && op_count > 0)
        begin
            if (op_stack[op_count - 1] == iee_pkg::OP_LPAREN)
                raise(iee_pkg::ST_MALFORMED);
            else
                apply_top();
        end
        if (err == iee_pkg::ST_OK && num_count != 1)
            raise(iee_pkg::ST_MALFORMED);
        o.status = err;
        o.value = (err == iee_pkg::ST_OK) ? num_stack[0] : 32'sd0;
        expected_outcomes.push_back(o);
        clear_eval();
    endtask

    // ---------------- stimulus ----------------
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        // drop valid for the gap; with no gap the next payload follows at once
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        last_char <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        evaluate_char(c, fin);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_digit();
        return iee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return iee_pkg::CH_ADD;
            1: return iee_pkg::CH_SUB;
            2: return iee_pkg::CH_MUL;
            default: return iee_pkg::CH_DIV;
        endcase
    endfunction

    // well-formed expression with random content, bounded nesting
    function automatic string build_expr(input int depth_left, input int terms);
        string s;
        s = "";
        for (int t = 0; t < terms; t++)
        begin
            if (t > 0)
                s = {s, string'(pick_operator())};
            if (depth_left > 0 && $urandom_range(0, 3) == 0)
                s = {s, "(", build_expr(depth_left - 1, $urandom_range(1, 3)), ")"};
            else
                s = {s, string'(pick_digit())};
        end
        return s;
    endfunction

    task automatic test_directed();
        send_text("0");
        send_text("9");
        send_text("1+2*3");
        send_text("(1+2)*3");
        send_text("8-3-2");
        send_text("9/2/2");
        send_text("7/0");
        send_text("0-7/2");
        send_text("-5");
        send_text("()");
        send_text("12");
        send_text("3)+4");
        send_text("(3+4");
        send_text(" 4 + a5 ");
        send_text("((((((((((((((((1))))))))))))))))");
        send_text("1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1");
        send_text("11111111111111111");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        // most negative value over -1
        send_text("(0-8*8*8*8*8*8*8*8*8*8*2)/(0-1)");
        send_text("9*9*9*9*9*9*9*9*9*9*9");
    endtask

    task automatic test_random_expressions(input int n_items);
        int sent;
        string s;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // noise: arbitrary bytes
                    int len;
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        send_char(8'($urandom), i == len - 1);
                    sent += len;
                end
                1:
                begin
                    // broken: drop or inject a character
                    s = build_expr(3, $urandom_range(1, 6));
                    if (s.len() > 1 && $urandom_range(0, 1))
                        s = s.substr(1, s.len() - 1);
                    else
                        s = {s, string'(pick_operator())};
                    send_text(s);
                    sent += s.len();
                end
                default:
                begin
                    s = build_expr(3, $urandom_range(1, 7));
                    send_text(s);
                    sent += s.len();
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        // hold the receiver off while the sender keeps offering
        hold_off = 1'b1;
        no_gaps = 1'b1;
        send_text("1+2");
        send_text("3*4");
        send_text("9-8");
        no_gaps = 1'b0;
        hold_off = 1'b0;
        in_valid <= 1'b0;
        // pause until everything has drained
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        no_gaps = 1'b1;
        send_text("(9+9)*(9/3)-8/2");
        no_gaps = 1'b0;
    endtask

    // ---------------- receiver ----------------
    initial
    begin
        int wait_cycles;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                while (hold_off)
                    @(posedge clk);
            end
            else if (out_valid && !out_stall)
            begin
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                out_stall <= (wait_cycles != 0);
                if (wait_cycles != 0)
                begin
                    repeat (wait_cycles) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // check each result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d status=%0d", value, status);
            end
            else
            begin
                outcome_t o;
                o = expected_outcomes.pop_front();
                if (o.value !== value || o.status !== status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%0d status=%0d, %s%0d status=%0d",
                                 o.value, o.status, "got value=", value, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        hold_off = 1'b0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_code = 8'h00;
        last_char = 1'b0;
        clear_eval();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_expressions(1030);
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
